FILE: rtl/cscan_pkg.sv
// Shared types and constants for the C-SCAN disk scheduler.
// No dependencies.
package cscan_pkg;

   localparam int CYL_W   = 16;
   localparam int TOTAL_W = 22;

   localparam logic [1:0] CSR_HEAD_START = 2'd0;
   localparam logic [1:0] CSR_CYL_LOW    = 2'd1;
   localparam logic [1:0] CSR_CYL_HIGH   = 2'd2;

   localparam logic [CYL_W-1:0] CYL_LOW_RESET  = 16'd0;
   localparam logic [CYL_W-1:0] CYL_HIGH_RESET = 16'd199;

   typedef struct packed {
      logic [CYL_W-1:0] cylinder;
      logic             last;
   } item_type;

   typedef struct packed {
      logic [CYL_W-1:0] head_start;
      logic [CYL_W-1:0] cyl_low;
      logic [CYL_W-1:0] cyl_high;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DECIDE,
      ST_END2
   } state_type;

endpackage

FILE: rtl/cscan_front.sv
// Request intake: two-entry queue in front of the scheduler.
// Depends on cscan_pkg.
module cscan_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  cscan_pkg::item_type push_item,
   output logic                item_valid,
   input  logic                item_pop,
   output cscan_pkg::item_type item
);
   import cscan_pkg::*;

   item_type   slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full       = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = slot_ff[rptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      wptr_in = wptr_ff ^ do_push;
      rptr_in = rptr_ff ^ do_pop;
      cnt_in  = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_item;
      end
   end

`ifndef ASSERT_OFF
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |=> (cnt_ff <= 2'd1))
      else $error("queue count jumped from empty");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("queue count out of range");
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (full && !item_pop) |=> full)
      else $error("full queue drained without pop");
`endif

endmodule

FILE: rtl/cscan_back.sv
// Scheduler core: request store, selection scan and move output register.
// Depends on cscan_pkg.
module cscan_back #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cscan_pkg::cfg_type         cfg,
   input  logic                       item_valid,
   output logic                       item_pop,
   input  cscan_pkg::item_type        item,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [cscan_pkg::CYL_W-1:0]   rsp_move_from,
   output logic [cscan_pkg::CYL_W-1:0]   rsp_move_to,
   output logic [cscan_pkg::CYL_W-1:0]   rsp_seek_distance,
   output logic [cscan_pkg::TOTAL_W-1:0] rsp_seek_total,
   output logic                       rsp_end_move,
   output logic                       rsp_overflow_seen,
   output logic                       rsp_schedule_last
);
   import cscan_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int KW = 1 + CYL_W + IW;

   logic [CYL_W-1:0] mem [QUEUE_DEPTH];

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             asc_ff, asc_in;
   logic             ends_ff, ends_in;
   logic [CW-1:0]    emitted_ff, emitted_in;
   logic [CW-1:0]    scan_ff, scan_in;
   logic             have_last_ff, have_last_in;
   logic [KW-1:0]    last_key_ff, last_key_in;
   logic             best_v_ff, best_v_in;
   logic [KW-1:0]    best_key_ff, best_key_in;
   logic [CYL_W-1:0] best_val_ff, best_val_in;
   logic [CYL_W-1:0] head_ff, head_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic             rd_v_ff, rd_v_in;
   logic [IW-1:0]    rd_idx_ff;
   logic [CYL_W-1:0] rd_data_ff;

   logic             mem_we;
   logic [IW-1:0]    mem_waddr;

   logic             emit, emit_end, emit_last;
   logic [CYL_W-1:0] emit_to, move_dist;
   logic             out_free;

   logic             rsp_v_ff;
   logic [CYL_W-1:0] from_ff, to_ff, dist_ff;
   logic [TOTAL_W-1:0] tot_ff;
   logic             end_ff, ovs_ff, slast_ff;

   logic [CYL_W-1:0] d_lo, d_hi, clamp_a, clamp_v;
   logic             cand_grp;
   logic [KW-1:0]    cand_key;
   logic             cand_ok;

   assign out_free  = !rsp_v_ff || rsp_pop;
   assign rsp_empty = !rsp_v_ff;

   // batch direction from head_start
   always_comb begin
      d_lo = (cfg.head_start > cfg.cyl_low) ? cfg.head_start - cfg.cyl_low
                                             : cfg.cyl_low - cfg.head_start;
      d_hi = (cfg.head_start > cfg.cyl_high) ? cfg.head_start - cfg.cyl_high
                                              : cfg.cyl_high - cfg.head_start;
   end

   // clamp and ordering key of the entry coming back from the store
   always_comb begin
      clamp_a  = (rd_data_ff < cfg.cyl_low) ? cfg.cyl_low : rd_data_ff;
      clamp_v  = (clamp_a > cfg.cyl_high) ? cfg.cyl_high : clamp_a;
      cand_grp = asc_ff ? (clamp_v < cfg.head_start) : (clamp_v >= cfg.head_start);
      cand_key = {cand_grp, (asc_ff ? clamp_v : ~clamp_v), rd_idx_ff};
      cand_ok  = rd_v_ff && (!have_last_ff || (cand_key > last_key_ff))
                 && (!best_v_ff || (cand_key < best_key_ff));
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      asc_in       = asc_ff;
      ends_in      = ends_ff;
      emitted_in   = emitted_ff;
      scan_in      = scan_ff;
      have_last_in = have_last_ff;
      last_key_in  = last_key_ff;
      best_v_in    = best_v_ff;
      best_key_in  = best_key_ff;
      best_val_in  = best_val_ff;
      head_in      = head_ff;
      rd_v_in      = 1'b0;
      item_pop     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[IW-1:0];
      emit         = 1'b0;
      emit_end     = 1'b0;
      emit_last    = 1'b0;
      emit_to      = best_val_ff;

      if (cand_ok) begin
         best_v_in   = 1'b1;
         best_key_in = cand_key;
         best_val_in = clamp_v;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (count_ff < CW'(QUEUE_DEPTH)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (item.last) begin
                  state_in     = ST_SCAN;
                  asc_in       = (d_lo >= d_hi);
                  head_in      = cfg.head_start;
                  ends_in      = 1'b0;
                  emitted_in   = '0;
                  have_last_in = 1'b0;
                  scan_in      = '0;
                  best_v_in    = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (scan_ff < count_ff) begin
               rd_v_in = 1'b1;
               scan_in = scan_ff + CW'(1);
            end else if (!rd_v_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               if (best_v_ff && (ends_ff || !best_key_ff[KW-1])) begin
                  emit         = 1'b1;
                  emit_to      = best_val_ff;
                  emit_last    = ends_ff && ((emitted_ff + CW'(1)) == count_ff);
                  emitted_in   = emitted_ff + CW'(1);
                  have_last_in = 1'b1;
                  last_key_in  = best_key_ff;
                  scan_in      = '0;
                  best_v_in    = 1'b0;
                  state_in     = ST_SCAN;
               end else begin
                  emit     = 1'b1;
                  emit_end = 1'b1;
                  emit_to  = asc_ff ? cfg.cyl_high : cfg.cyl_low;
                  state_in = ST_END2;
               end
            end
         end
         ST_END2: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_end  = 1'b1;
               emit_to   = asc_ff ? cfg.cyl_low : cfg.cyl_high;
               emit_last = (emitted_ff == count_ff);
               ends_in   = 1'b1;
               state_in  = ST_DECIDE;
            end
         end
         default: state_in = ST_LOAD;
      endcase

      if (emit) begin
         head_in = emit_to;
      end
      if (emit_last) begin
         state_in   = ST_LOAD;
         count_in   = '0;
         ovf_in     = 1'b0;
         emitted_in = '0;
      end
   end

   always_comb begin
      move_dist = (head_ff > emit_to) ? head_ff - emit_to : emit_to - head_ff;
      total_in  = total_ff + TOTAL_W'(move_dist);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         ends_ff      <= 1'b0;
         emitted_ff   <= '0;
         scan_ff      <= '0;
         have_last_ff <= 1'b0;
         best_v_ff    <= 1'b0;
         rd_v_ff      <= 1'b0;
         head_ff      <= '0;
         total_ff     <= '0;
         rsp_v_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         ends_ff      <= ends_in;
         emitted_ff   <= emitted_in;
         scan_ff      <= scan_in;
         have_last_ff <= have_last_in;
         best_v_ff    <= best_v_in;
         rd_v_ff      <= rd_v_in;
         head_ff      <= head_in;
         if (emit_last || (state_ff == ST_LOAD)) begin
            total_ff <= '0;
         end else if (emit) begin
            total_ff <= total_in;
         end
         if (emit) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      asc_ff      <= asc_in;
      last_key_ff <= last_key_in;
      best_key_ff <= best_key_in;
      best_val_ff <= best_val_in;
      rd_idx_ff   <= scan_ff[IW-1:0];
      rd_data_ff  <= mem[scan_ff[IW-1:0]];
      if (mem_we) begin
         mem[mem_waddr] <= item.cylinder;
      end
      if (emit) begin
         from_ff  <= head_ff;
         to_ff    <= emit_to;
         dist_ff  <= move_dist;
         tot_ff   <= total_in;
         end_ff   <= emit_end;
         ovs_ff   <= ovf_ff;
         slast_ff <= emit_last;
      end
   end

   assign rsp_move_from     = from_ff;
   assign rsp_move_to       = to_ff;
   assign rsp_seek_distance = dist_ff;
   assign rsp_seek_total    = tot_ff;
   assign rsp_end_move      = end_ff;
   assign rsp_overflow_seen = ovs_ff;
   assign rsp_schedule_last = slast_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("request count beyond store depth");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (emit && rsp_v_ff) |-> rsp_pop)
      else $error("move overwrote an untaken result");
   a_emitted_bound: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= count_ff)
      else $error("more request moves than stored requests");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      emit_last |=> (count_ff == '0) && (state_ff == ST_LOAD))
      else $error("batch state not cleared after final move");
`endif

endmodule

FILE: rtl/cscan_disk_schedule_top.sv
// C-SCAN disk scheduler top level: configuration registers, intake and core.
// Depends on cscan_pkg, cscan_front and cscan_back.
//
// Usage:
//   req_ channel is a queue write port: push a cylinder when full is low,
//   with batch_last on the final request of a batch. Requests are loaded
//   into the store only in the load state; QUEUE_DEPTH requests are kept,
//   later ones are dropped and the batch's moves report overflow_seen.
//   After batch_last the core emits n+2 moves (n stored requests) on the rsp_
//   channel, read like a queue: a move is shown while rsp_empty is low and is
//   taken by rsp_pop. The next move is chosen by a scan over the store that
//   reads one entry per cycle; each request move takes a full scan and then
//   an issue step that waits while the output register holds an untaken
//   move, and the two sweep-end moves are issued without a scan.
//   Requests of the next batch queue up in the two-entry intake while a
//   schedule runs. If the receiver stalls, the core holds the move in its
//   output register and waits.
//   csr_ writes (index 0 head_start, 1 cylinder_low, 2 cylinder_high) are
//   always ready and are to be done while no batch is in flight.
//   Reset empties the intake and store, sets head_start 0, cylinder_low 0,
//   cylinder_high 199.
module cscan_disk_schedule_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          full,
   input  logic [cscan_pkg::CYL_W-1:0]   req_request_cylinder,
   input  logic                          req_batch_last,
   output logic                          empty,
   input  logic                          pop,
   output logic [cscan_pkg::CYL_W-1:0]   rsp_move_from,
   output logic [cscan_pkg::CYL_W-1:0]   rsp_move_to,
   output logic [cscan_pkg::CYL_W-1:0]   rsp_seek_distance,
   output logic [cscan_pkg::TOTAL_W-1:0] rsp_seek_total,
   output logic                          rsp_end_move,
   output logic                          rsp_overflow_seen,
   output logic                          rsp_schedule_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [cscan_pkg::CYL_W-1:0]   csr_data
);
   import cscan_pkg::*;

   cfg_type  cfg_ff;
   item_type push_item, item;
   logic     item_valid, item_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_start <= '0;
         cfg_ff.cyl_low    <= CYL_LOW_RESET;
         cfg_ff.cyl_high   <= CYL_HIGH_RESET;
      end else if (csr_valid && csr_ready) begin
         priority case (csr_index)
            CSR_HEAD_START: cfg_ff.head_start <= csr_data;
            CSR_CYL_LOW:    cfg_ff.cyl_low    <= csr_data;
            CSR_CYL_HIGH:   cfg_ff.cyl_high   <= csr_data;
            default: ;
         endcase
      end
   end

   assign push_item.cylinder = req_request_cylinder;
   assign push_item.last     = req_batch_last;

   cscan_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (full),
      .push_item  (push_item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   cscan_back #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .item_valid        (item_valid),
      .item_pop          (item_pop),
      .item              (item),
      .rsp_empty         (empty),
      .rsp_pop           (pop),
      .rsp_move_from     (rsp_move_from),
      .rsp_move_to       (rsp_move_to),
      .rsp_seek_distance (rsp_seek_distance),
      .rsp_seek_total    (rsp_seek_total),
      .rsp_end_move      (rsp_end_move),
      .rsp_overflow_seen (rsp_overflow_seen),
      .rsp_schedule_last (rsp_schedule_last)
   );

endmodule

FILE: dv/cscan_disk_schedule_tb.sv
// Self-checking testbench for the C-SCAN disk scheduler.
// Depends on cscan_pkg and cscan_disk_schedule_top; predicts every head move.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cscan_pkg::*;

   localparam int DEPTH = 16;

   typedef struct packed {
      logic [CYL_W-1:0]   from_cyl;
      logic [CYL_W-1:0]   to_cyl;
      logic [CYL_W-1:0]   seek;
      logic [TOTAL_W-1:0] total;
      logic               end_mv;
      logic               ovf;
      logic               last;
   } move_type;

   class cscan_scoreboard;
      cfg_type          cfg;
      logic [CYL_W-1:0] held[$];
      logic             dropped;
      logic [CYL_W-1:0] head;
      logic [TOTAL_W-1:0] total;
      move_type         pending_moves[$];
      int               errors;
      int               moves_checked;
      int               batches;

      function new();
         cfg.head_start = '0;
         cfg.cyl_low = CYL_LOW_RESET;
         cfg.cyl_high = CYL_HIGH_RESET;
         dropped = 1'b0;
         head = '0;
         total = '0;
         errors = 0;
         moves_checked = 0;
         batches = 0;
      endfunction

      function void add_move(logic [CYL_W-1:0] to_cyl, logic end_mv);
         move_type m;
         m.from_cyl = head;
         m.to_cyl = to_cyl;
         m.seek = (head > to_cyl) ? head - to_cyl : to_cyl - head;
         total = total + m.seek;
         m.total = total;
         m.end_mv = end_mv;
         m.ovf = dropped;
         m.last = 1'b0;
         head = to_cyl;
         pending_moves.push_back(m);
      endfunction

      function void note_request(logic [CYL_W-1:0] cyl, logic last);
         logic [CYL_W-1:0] up[$];
         logic [CYL_W-1:0] dn[$];
         logic [CYL_W-1:0] r;
         logic [CYL_W-1:0] h, lo, hi, d_lo, d_hi;
         move_type m;
         if (held.size() < DEPTH) held.push_back(cyl);
         else dropped = 1'b1;
         if (!last) return;
         h = cfg.head_start;
         lo = cfg.cyl_low;
         hi = cfg.cyl_high;
         foreach (held[i]) begin
            r = held[i];
            if (r < lo) r = lo;
            if (r > hi) r = hi;
            if (r >= h) up.push_back(r);
            else dn.push_back(r);
         end
         up.sort();
         dn.sort();
         head = h;
         total = '0;
         d_lo = (h > lo) ? h - lo : lo - h;
         d_hi = (h > hi) ? h - hi : hi - h;
         if (d_lo >= d_hi) begin
            foreach (up[i]) add_move(up[i], 1'b0);
            add_move(hi, 1'b1);
            add_move(lo, 1'b1);
            foreach (dn[i]) add_move(dn[i], 1'b0);
         end else begin
            for (int i = dn.size() - 1; i >= 0; i--) add_move(dn[i], 1'b0);
            add_move(lo, 1'b1);
            add_move(hi, 1'b1);
            for (int i = up.size() - 1; i >= 0; i--) add_move(up[i], 1'b0);
         end
         m = pending_moves.pop_back();
         m.last = 1'b1;
         pending_moves.push_back(m);
         held.delete();
         dropped = 1'b0;
         total = '0;
         batches++;
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("ERROR %0t: %s got %0d want %0d", $realtime, what, got, want);
      endtask

      task check_move(move_type got);
         move_type want;
         if (pending_moves.size() == 0) begin
            report("unexpected move, to", got.to_cyl, 0);
            return;
         end
         want = pending_moves.pop_front();
         moves_checked++;
         if (got.from_cyl != want.from_cyl) report("move_from", got.from_cyl, want.from_cyl);
         if (got.to_cyl != want.to_cyl) report("move_to", got.to_cyl, want.to_cyl);
         if (got.seek != want.seek) report("seek_distance", got.seek, want.seek);
         if (got.total != want.total) report("seek_total", got.total, want.total);
         if (got.end_mv != want.end_mv) report("end_move", got.end_mv, want.end_mv);
         if (got.ovf != want.ovf) report("overflow_seen", got.ovf, want.ovf);
         if (got.last != want.last) report("schedule_last", got.last, want.last);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic full;
   logic [CYL_W-1:0] req_request_cylinder = '0;
   logic req_batch_last = 1'b0;
   logic empty;
   logic pop = 1'b0;
   logic [CYL_W-1:0] rsp_move_from, rsp_move_to, rsp_seek_distance;
   logic [TOTAL_W-1:0] rsp_seek_total;
   logic rsp_end_move, rsp_overflow_seen, rsp_schedule_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_HEAD_START;
   logic [CYL_W-1:0] csr_data = '0;

   int send_idle_pct = 19;
   int recv_idle_pct = 88;
   bit draining = 1'b0;
   cscan_scoreboard sb = new();

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   cscan_disk_schedule_top #(.QUEUE_DEPTH(DEPTH)) DUT (.*);

   // receiver: sample on rising edge, change pop on falling edge
   always @(posedge clock) begin
      if (!reset && pop && !empty)
         sb.check_move({rsp_move_from, rsp_move_to, rsp_seek_distance, rsp_seek_total,
                        rsp_end_move, rsp_overflow_seen, rsp_schedule_last});
   end

   always @(negedge clock) begin
      if (reset) pop <= 1'b0;
      else pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // push stays high into the next request unless the sender idles
   task automatic send_request(logic [CYL_W-1:0] cyl, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_request_cylinder <= cyl;
      req_batch_last <= last;
      do @(posedge clock); while (full);
      sb.note_request(cyl, last);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (sb.pending_moves.size() != 0) @(negedge clock);
      // the core may still be clearing after the last move
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [CYL_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_HEAD_START: sb.cfg.head_start = val;
         CSR_CYL_LOW:    sb.cfg.cyl_low = val;
         default:        sb.cfg.cyl_high = val;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(logic [CYL_W-1:0] h, logic [CYL_W-1:0] lo,
                             logic [CYL_W-1:0] hi);
      wait_drained();
      write_reg(CSR_HEAD_START, h);
      write_reg(CSR_CYL_LOW, lo);
      write_reg(CSR_CYL_HIGH, hi);
      csr_valid <= 1'b0;
   endtask

   // mostly in-range cylinders, some anywhere in 16 bits
   function automatic logic [CYL_W-1:0] pick_cyl();
      logic [CYL_W-1:0] lo, hi;
      lo = (sb.cfg.cyl_low < sb.cfg.cyl_high) ? sb.cfg.cyl_low : sb.cfg.cyl_high;
      hi = (sb.cfg.cyl_low < sb.cfg.cyl_high) ? sb.cfg.cyl_high : sb.cfg.cyl_low;
      if ($urandom_range(9) < 7) return CYL_W'($urandom_range(hi, lo));
      return CYL_W'($urandom());
   endfunction

   task automatic random_batch();
      int n;
      n = ($urandom_range(19) == 0) ? $urandom_range(20, 17) : $urandom_range(6, 1);
      for (int i = 0; i < n; i++) send_request(pick_cyl(), i == n - 1);
   endtask

   task automatic random_config();
      case ($urandom_range(4))
         0: set_config(CYL_W'($urandom()), 16'd0, 16'hFFFF);
         1: set_config(CYL_W'($urandom_range(300)), 16'd0, 16'd199);
         2: set_config(CYL_W'($urandom()), 16'd50000, 16'd1000);
         3: set_config(CYL_W'($urandom()), CYL_W'($urandom()), CYL_W'($urandom()));
         default: set_config(16'hFFFF, 16'd100, 16'd60000);
      endcase
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: extremes, overflow, both sweep directions, clamping
      send_request(16'd0, 1'b0);
      send_request(16'hFFFF, 1'b0);
      send_request(16'd100, 1'b1);
      set_config(16'd150, 16'd0, 16'd199);
      send_request(16'd10, 1'b0);
      send_request(16'd180, 1'b0);
      send_request(16'd150, 1'b1);
      set_config(16'hFFFF, 16'd0, 16'hFFFF);
      for (int i = 0; i < 18; i++) send_request(16'h5555 ^ CYL_W'(i * 4099), i == 17);
      // reversed ends
      set_config(16'hAAAA, 16'd2000, 16'd1000);
      send_request(16'd1500, 1'b1);
      send_request(16'd0, 1'b0);
      send_request(16'h8000, 1'b1);
      // hold off until all moves are back
      wait_drained();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 88 : 0;
         recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 19 : 0;
         for (int b = 0; b < 16; b++) begin
            if ($urandom_range(3) == 0) random_config();
            random_batch();
         end
      end
      wait_drained();
      $display("covered %0d batches, %0d moves checked, incl. overflow and reversed ends",
               sb.batches, sb.moves_checked);
      if (sb.errors == 0 && sb.pending_moves.size() == 0)
         $display("cscan_disk_schedule_top: match");
      else
         $display("cscan_disk_schedule_top: mismatch");
      $finish;
   end

   initial begin
      #5ms;
      $display("cscan_disk_schedule_top: mismatch");
      $finish;
   end
endmodule
